[hdl/assert_macros.svh]
// assertion macros used by the checker file kmd_checker.sv
// depends on nothing; take in with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define KMD_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define KMD_ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/kmd_pkg.sv]
// shared types and constants of the key matrix debounce block
// no dependencies
`default_nettype none

package kmd_pkg;

  localparam int MAX_LANES = 8;   // columns carried by one row sample
  localparam int ROW_W     = 3;   // width of the row index field
  localparam int COL_W     = 3;   // width of the column index field
  localparam int TIME_W    = 32;
  localparam int DEB_W     = 16;
  localparam int SHIFT_W   = 6;
  localparam int MASK_W    = 64;
  localparam int KEY_IDX_W = 9;   // holds row*COLS+col for the largest matrix
  localparam int CFG_AW    = 5;
  localparam int CFG_DW    = 64;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_SHIFT_KEY  = 2'd1,
    REG_PRINT_MASK = 2'd2
  } kmd_reg_t;

  // events found in one row sample, one bit per column
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [MAX_LANES-1:0] fire;
    logic [MAX_LANES-1:0] press;
    logic [MAX_LANES-1:0] shft;
    logic [MAX_LANES-1:0] prnt;
  } kmd_ev_t;

  // merge stage status seen by the lane stage
  typedef struct packed {
    logic busy;
    logic done;
  } kmd_mrg_stat_t;

endpackage

`default_nettype wire

[hdl/kmd_ram.sv]
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module kmd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/kmd_lane.sv]
// one column lane: raw change capture, hold time check, stable change detect
// uses kmd_pkg for widths
`default_nettype none

module kmd_lane (
  input  wire logic                        pressed,
  input  wire logic                        raw_old,
  input  wire logic                        stable_old,
  input  wire logic [kmd_pkg::TIME_W-1:0]  ct_old,
  input  wire logic [kmd_pkg::TIME_W-1:0]  now_ms,
  input  wire logic [kmd_pkg::DEB_W-1:0]   debounce_ms,
  output logic      [kmd_pkg::TIME_W-1:0]  ct_new,
  output logic                             fire
);

  logic [kmd_pkg::TIME_W-1:0] held;

  always_comb begin
    ct_new = (pressed != raw_old) ? now_ms : ct_old;
    held   = now_ms - ct_new;   // wraps modulo 2^32
    fire   = (held >= kmd_pkg::TIME_W'(debounce_ms)) && (pressed != stable_old);
  end

endmodule

`default_nettype wire

[hdl/kmd_merge.sv]
// merge stage: holds one row's events, sends them out lowest column first,
// keeps the sticky shift; uses kmd_pkg
`default_nettype none

module kmd_merge (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          ld,
  input  wire kmd_pkg::kmd_ev_t              ld_ev,
  output kmd_pkg::kmd_mrg_stat_t             stat,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [kmd_pkg::ROW_W-1:0]          out_key_row,
  output logic [kmd_pkg::COL_W-1:0]          out_key_col,
  output logic                               out_is_press,
  output logic                               out_shift_flag,
  output logic                               out_last_of_run
);

  kmd_pkg::kmd_ev_t                 ev_r, ev_nxt;
  logic                             ev_valid_r, ev_valid_nxt;
  logic                             sticky_r, sticky_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [kmd_pkg::ROW_W-1:0]        row_r;
  logic [kmd_pkg::COL_W-1:0]        col_r;
  logic                             press_r, flag_r, last_r;

  logic [kmd_pkg::COL_W-1:0]        sel;
  logic [kmd_pkg::MAX_LANES-1:0]    rest;
  logic                             emit, last, flag, s_press, s_shft, s_prnt;

  // lowest pending column
  always_comb begin
    sel = '0;
    for (int i = kmd_pkg::MAX_LANES - 1; i >= 0; i--) begin
      if (ev_r.fire[i]) begin
        sel = kmd_pkg::COL_W'(i);
      end
    end
  end

  always_comb begin
    emit    = ev_valid_r && (!out_valid_r || out_ready);
    rest    = ev_r.fire & ~(kmd_pkg::MAX_LANES'(1) << sel);
    last    = (rest == '0);
    s_press = ev_r.press[sel];
    s_shft  = ev_r.shft[sel];
    s_prnt  = ev_r.prnt[sel];

    sticky_nxt = sticky_r;
    if (emit && s_shft && s_press) begin
      sticky_nxt = ~sticky_r;
    end
    flag = sticky_nxt;
    if (emit && s_press && sticky_nxt && !s_shft && s_prnt) begin
      sticky_nxt = 1'b0;
      flag       = 1'b1;
    end

    stat.busy = ev_valid_r;
    stat.done = emit && last;

    ev_nxt       = ev_r;
    ev_valid_nxt = ev_valid_r;
    if (emit) begin
      ev_nxt.fire = rest;
      if (last) begin
        ev_valid_nxt = 1'b0;
      end
    end
    if (ld) begin
      ev_nxt       = ld_ev;
      ev_valid_nxt = 1'b1;
    end

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r  <= 1'b0;
      sticky_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ev_valid_r  <= ev_valid_nxt;
      sticky_r    <= sticky_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_r <= ev_nxt;
    if (emit) begin
      row_r   <= ev_r.row;
      col_r   <= sel;
      press_r <= s_press;
      flag_r  <= flag;
      last_r  <= last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_row     = row_r;
  assign out_key_col     = col_r;
  assign out_is_press    = press_r;
  assign out_shift_flag  = flag_r;
  assign out_last_of_run = last_r;

endmodule

`default_nettype wire

[hdl/key_matrix_debounce_events_top.sv]
// top level of the key matrix debounce block: config registers, lane stage, time ram
// depends on kmd_pkg, kmd_ram, kmd_lane, kmd_merge
`default_nettype none

// Key matrix debounce with key events. Each input transfer carries one
// sampled row: the row index, one level bit per column and the current time
// in ms. The item is registered when taken; in the next cycle one lane per
// column (min(COLS,8) lanes) compares against the stored raw level, stable
// level and change time of its key and flags a stable change. The flagged
// keys of a row go to the merge stage, which sends one event transfer per
// cycle while out_ready allows, lowest column first, with the sticky shift
// applied in that order and last_of_run on the final event of the row. A
// row with events waits until the merge stage is idle or sends the final
// event of the previous row; a row with no events, or out of range, never
// waits. The event serialiser sets the rate. An event passes the input,
// merge and output registers. Change times live in a ram of one row per
// entry (32 bits per column), with a valid bit per row in place of a
// clearing pass, so the block is ready straight out of reset. Registers:
// debounce_ms at 0x00, shift_key_index at 0x08, printable_mask at 0x10;
// write them only while the block is idle.
module key_matrix_debounce_events_top #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // row samples
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [kmd_pkg::ROW_W-1:0]       in_scan_row,
  input  wire logic [kmd_pkg::MAX_LANES-1:0]   in_column_levels,
  input  wire logic [kmd_pkg::TIME_W-1:0]      in_now_ms,
  // key events
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [kmd_pkg::ROW_W-1:0]            out_key_row,
  output logic [kmd_pkg::COL_W-1:0]            out_key_col,
  output logic                                 out_is_press,
  output logic                                 out_shift_flag,
  output logic                                 out_last_of_run,
  // register port
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [kmd_pkg::CFG_AW-1:0]      paddr,
  input  wire logic [kmd_pkg::CFG_DW-1:0]      pwdata,
  output logic      [kmd_pkg::CFG_DW-1:0]      prdata,
  output logic                                 pready
);

  // only columns that the sample carries get a lane
  localparam int LANES    = (COLS < kmd_pkg::MAX_LANES) ? COLS : kmd_pkg::MAX_LANES;
  // rows beyond the reach of the row field are never visited
  localparam int ROW_SPAN = 1 << kmd_pkg::ROW_W;
  localparam int RROWS    = (ROWS < ROW_SPAN) ? ROWS : ROW_SPAN;
  localparam int RAW      = (RROWS > 1) ? $clog2(RROWS) : 1;
  localparam int TW       = kmd_pkg::TIME_W * LANES;
  localparam int KW       = kmd_pkg::KEY_IDX_W;

  // ---------------- configuration registers ----------------
  logic [kmd_pkg::DEB_W-1:0]   deb_r;
  logic [kmd_pkg::SHIFT_W-1:0] shift_idx_r;
  logic [kmd_pkg::MASK_W-1:0]  pmask_r;
  logic                        cfg_wr;
  kmd_pkg::kmd_reg_t           cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  // the register index is taken from the 8-byte slot, low address bits ignored
  assign cfg_sel = kmd_pkg::kmd_reg_t'(paddr[4:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r       <= kmd_pkg::DEB_W'(20);
      shift_idx_r <= '0;
      pmask_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        kmd_pkg::REG_DEBOUNCE:   deb_r       <= pwdata[kmd_pkg::DEB_W-1:0];
        kmd_pkg::REG_SHIFT_KEY:  shift_idx_r <= pwdata[kmd_pkg::SHIFT_W-1:0];
        kmd_pkg::REG_PRINT_MASK: pmask_r     <= pwdata;
        default: ;   // slot with no register
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      kmd_pkg::REG_DEBOUNCE:   prdata = kmd_pkg::CFG_DW'(deb_r);
      kmd_pkg::REG_SHIFT_KEY:  prdata = kmd_pkg::CFG_DW'(shift_idx_r);
      kmd_pkg::REG_PRINT_MASK: prdata = pmask_r;
      default:                 prdata = '0;
    endcase
  end

  // ---------------- input stage ----------------
  logic                          s1_valid_r, s1_valid_nxt;
  logic [kmd_pkg::ROW_W-1:0]     s1_row_r;
  logic [kmd_pkg::MAX_LANES-1:0] s1_lvl_r;
  logic [kmd_pkg::TIME_W-1:0]    s1_now_r;
  logic                          in_acc, s1_go, any_fire, in_range, upd;
  kmd_pkg::kmd_mrg_stat_t        mstat;

  // a new row may enter while the previous one leaves the lane stage
  assign in_ready = !s1_valid_r || s1_go;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r <= in_scan_row;
      s1_lvl_r <= in_column_levels;
      s1_now_r <= in_now_ms;
    end
  end

  // ---------------- per key state ----------------
  logic [RAW-1:0]              s1_addr;
  logic [RROWS-1:0]            row_vld_r;   // row of change times written at least once
  logic [LANES-1:0]            raw_r    [RROWS];
  logic [LANES-1:0]            stable_r [RROWS];
  logic                        byp_valid_r;
  logic [RAW-1:0]              byp_row_r;
  logic [TW-1:0]               byp_data_r;
  logic [TW-1:0]               ram_rdata, ct_row, ct_new;
  logic                        byp_hit;
  logic [LANES-1:0]            raw_row, stable_row, stable_new;

  assign s1_addr  = s1_row_r[RAW-1:0];
  assign in_range = (32'(s1_row_r) < ROWS);
  assign upd      = s1_go && in_range;

  kmd_ram #(
    .WIDTH (TW),
    .DEPTH (RROWS)
  ) u_time_ram (
    .clk   (clk),
    .we    (upd),
    .waddr (s1_addr),
    .wdata (ct_new),
    .re    (in_acc),
    .raddr (in_scan_row[RAW-1:0]),
    .rdata (ram_rdata)
  );

  // the last row write may not be in the ram read yet: take it from the bypass
  assign byp_hit    = byp_valid_r && (byp_row_r == s1_addr);
  assign ct_row     = byp_hit ? byp_data_r : (row_vld_r[s1_addr] ? ram_rdata : '0);
  assign raw_row    = raw_r[s1_addr];
  assign stable_row = stable_r[s1_addr];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r   <= '0;
      byp_valid_r <= 1'b0;
      for (int r = 0; r < RROWS; r++) begin
        raw_r[r]    <= '0;
        stable_r[r] <= '0;
      end
    end else if (upd) begin
      row_vld_r[s1_addr] <= 1'b1;
      byp_valid_r        <= 1'b1;
      raw_r[s1_addr]     <= s1_lvl_r[LANES-1:0];
      stable_r[s1_addr]  <= stable_new;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      byp_row_r  <= s1_addr;
      byp_data_r <= ct_new;
    end
  end

  // ---------------- column lanes ----------------
  kmd_pkg::kmd_ev_t ev;
  logic [kmd_pkg::MAX_LANES-1:0] lane_fire;

  assign ev.row = s1_row_r;

  for (genvar l = 0; l < kmd_pkg::MAX_LANES; l++) begin : g_lane
    if (l < LANES) begin : g_on
      logic [KW-1:0] kidx;
      logic          lfire;

      kmd_lane u_lane (
        .pressed     (s1_lvl_r[l]),
        .raw_old     (raw_row[l]),
        .stable_old  (stable_row[l]),
        .ct_old      (ct_row[l*kmd_pkg::TIME_W +: kmd_pkg::TIME_W]),
        .now_ms      (s1_now_r),
        .debounce_ms (deb_r),
        .ct_new      (ct_new[l*kmd_pkg::TIME_W +: kmd_pkg::TIME_W]),
        .fire        (lfire)
      );

      // key index row*COLS+col; indexes of 64 and up are neither shift nor printable
      assign kidx          = KW'(s1_row_r) * KW'(COLS) + KW'(l);
      assign lane_fire[l]  = lfire && in_range;
      assign stable_new[l] = stable_row[l] ^ lfire;
      assign ev.press[l]   = s1_lvl_r[l];
      assign ev.shft[l]    = (kidx[KW-1:kmd_pkg::SHIFT_W] == '0) &&
                             (kidx[kmd_pkg::SHIFT_W-1:0] == shift_idx_r);
      assign ev.prnt[l]    = (kidx[KW-1:kmd_pkg::SHIFT_W] == '0) &&
                             pmask_r[kidx[kmd_pkg::SHIFT_W-1:0]];
    end else begin : g_off
      assign lane_fire[l] = 1'b0;
      assign ev.press[l]  = 1'b0;
      assign ev.shft[l]   = 1'b0;
      assign ev.prnt[l]   = 1'b0;
    end
  end

  assign ev.fire  = lane_fire;
  assign any_fire = |lane_fire;

  // rows with no events never wait for the merge stage
  assign s1_go = s1_valid_r && (!mstat.busy || mstat.done || !any_fire);

  // ---------------- merge and output ----------------
  kmd_merge u_merge (
    .clk             (clk),
    .rst_n           (rst_n),
    .ld              (s1_go && any_fire),
    .ld_ev           (ev),
    .stat            (mstat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_key_row     (out_key_row),
    .out_key_col     (out_key_col),
    .out_is_press    (out_is_press),
    .out_shift_flag  (out_shift_flag),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire

[hdl/kmd_checker.sv]
// port level checks on the key matrix debounce top, bound to it below
// depends on kmd_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module kmd_checker #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [kmd_pkg::ROW_W-1:0]   out_key_row,
  input wire logic [kmd_pkg::COL_W-1:0]   out_key_col,
  input wire logic                        out_is_press,
  input wire logic                        out_shift_flag,
  input wire logic                        out_last_of_run,
  input wire logic                        pready
);

  // a stalled event stays offered
  `KMD_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "event dropped while stalled")

  // events only name keys that exist
  `KMD_ASSERT_RST(a_row_range, clk, rst_n, out_valid |-> (32'(out_key_row) < ROWS), "event row outside matrix")
  `KMD_ASSERT_RST(a_col_range, clk, rst_n, out_valid |-> (32'(out_key_col) < COLS), "event column outside matrix")

  // a stalled event keeps its fields
  `KMD_ASSERT_RST(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_key_row) && $stable(out_key_col) && $stable(out_is_press) && $stable(out_shift_flag) && $stable(out_last_of_run), "stalled event changed")

  // register port never inserts wait states
  `KMD_ASSERT_CLK(a_pready, clk, pready, "pready low")

endmodule

bind key_matrix_debounce_events_top kmd_checker #(
  .ROWS (ROWS),
  .COLS (COLS)
) u_kmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_key_row     (out_key_row),
  .out_key_col     (out_key_col),
  .out_is_press    (out_is_press),
  .out_shift_flag  (out_shift_flag),
  .out_last_of_run (out_last_of_run),
  .pready          (pready)
);

`default_nettype wire

[tb/sv/tb_top.sv]
// self-checking testbench for key_matrix_debounce_events_top: row samples in, key events out
// depends on kmd_pkg and the top level; carries its own predictor of the debounce behaviour
module tb_top;

  localparam int ROWS = 8;
  localparam int COLS = 8;
  localparam int NKEYS = ROWS * COLS;
  localparam int IDLE_SETTLE = 16;       // cycles for rows that yield no events to clear the pipe
  localparam int DRAIN_CYCLES = 32;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  // one key event as seen on the result channel
  typedef struct {
    logic [kmd_pkg::ROW_W-1:0] row;
    logic [kmd_pkg::COL_W-1:0] col;
    logic press;
    logic shift;
    logic last;
  } key_event_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [kmd_pkg::ROW_W-1:0] in_scan_row;
  logic [kmd_pkg::MAX_LANES-1:0] in_column_levels;
  logic [kmd_pkg::TIME_W-1:0] in_now_ms;
  logic out_valid;
  logic out_ready;
  logic [kmd_pkg::ROW_W-1:0] out_key_row;
  logic [kmd_pkg::COL_W-1:0] out_key_col;
  logic out_is_press;
  logic out_shift_flag;
  logic out_last_of_run;
  logic psel;
  logic penable;
  logic pwrite;
  logic [kmd_pkg::CFG_AW-1:0] paddr;
  logic [kmd_pkg::CFG_DW-1:0] pwdata;
  logic [kmd_pkg::CFG_DW-1:0] prdata;
  logic pready;

  // predictor copy of the register settings
  logic [kmd_pkg::DEB_W-1:0] cfg_debounce;
  logic [kmd_pkg::SHIFT_W-1:0] cfg_shift_key;
  logic [kmd_pkg::MASK_W-1:0] cfg_printable;

  // predictor copy of the per-key debounce state and the sticky shift
  logic key_raw [NKEYS];
  logic key_stable [NKEYS];
  logic [kmd_pkg::TIME_W-1:0] key_changed_at [NKEYS];
  logic shift_latched;

  key_event_t pending_events[$];

  // stimulus shaping shared between the sender and the receiver
  logic [kmd_pkg::MAX_LANES-1:0] row_target [ROWS];
  logic [kmd_pkg::TIME_W-1:0] scan_clock;
  bit steady_flow;
  bit hold_request;

  int error_count;
  int cycle_count;
  int rows_sent;
  int events_checked;
  int presses_seen;
  int shifted_seen;

  key_matrix_debounce_events_top #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_scan_row(in_scan_row),
    .in_column_levels(in_column_levels),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key_row(out_key_row),
    .out_key_col(out_key_col),
    .out_is_press(out_is_press),
    .out_shift_flag(out_shift_flag),
    .out_last_of_run(out_last_of_run),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 8 time unit clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // hard stop in case a handshake never completes
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events still awaited",
               cycle_count, pending_events.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 92) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  // works out the events one row sample causes, columns in ascending order,
  // and queues them with last_of_run on the final one
  function automatic void predict_key_events(input logic [kmd_pkg::ROW_W-1:0] row,
                                             input logic [kmd_pkg::MAX_LANES-1:0] levels,
                                             input logic [kmd_pkg::TIME_W-1:0] now);
    int unsigned idx;
    logic [kmd_pkg::TIME_W-1:0] held_for;
    logic pressed;
    logic is_shift;
    logic flag;
    key_event_t ev;
    key_event_t run_events[$];
    if (row >= ROWS) return;
    for (int c = 0; c < COLS && c < kmd_pkg::MAX_LANES; c++) begin
      idx = row * COLS + c;
      if (idx >= NKEYS) break;
      pressed = levels[c];
      if (pressed != key_raw[idx]) begin
        key_raw[idx] = pressed;
        key_changed_at[idx] = now;
      end
      // wrapping difference, so a run across the 32-bit rollover still counts
      held_for = now - key_changed_at[idx];
      if (held_for < kmd_pkg::TIME_W'(cfg_debounce) || pressed == key_stable[idx]) continue;
      key_stable[idx] = pressed;
      is_shift = (idx < 64) && (idx == cfg_shift_key);
      if (is_shift && pressed) shift_latched = ~shift_latched;
      flag = shift_latched;
      // a printable press consumes the sticky shift but still reports it
      if (pressed && shift_latched && !is_shift && idx < 64 && cfg_printable[idx]) begin
        shift_latched = 1'b0;
        flag = 1'b1;
      end
      ev.row = row;
      ev.col = kmd_pkg::COL_W'(c);
      ev.press = pressed;
      ev.shift = flag;
      ev.last = 1'b0;
      run_events.push_back(ev);
    end
    if (run_events.size() > 0) run_events[run_events.size() - 1].last = 1'b1;
    foreach (run_events[i]) pending_events.push_back(run_events[i]);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] expv,
                                      input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      error_count++;
    end
  endfunction

  // result side: every event transfer is matched against the oldest prediction
  always @(posedge clk) begin
    key_event_t exp_ev;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $error("unexpected event: row %0d col %0d press %0b shift %0b last %0b",
               out_key_row, out_key_col, out_is_press, out_shift_flag, out_last_of_run);
        error_count++;
      end else begin
        exp_ev = pending_events.pop_front();
        check_field("key_row", 32'(exp_ev.row), 32'(out_key_row));
        check_field("key_col", 32'(exp_ev.col), 32'(out_key_col));
        check_field("is_press", 32'(exp_ev.press), 32'(out_is_press));
        check_field("shift_flag", 32'(exp_ev.shift), 32'(out_shift_flag));
        check_field("last_of_run", 32'(exp_ev.last), 32'(out_last_of_run));
        events_checked++;
        if (exp_ev.press) presses_seen++;
        if (exp_ev.shift) shifted_seen++;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request so the
  // event serialiser backs up into the input channel
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_ready <= 1'b1;
      end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(negedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // one row sample transfer; valid is left high so a following item can
  // go out back to back, and the prediction is made at the accepting edge
  task automatic send_row(input logic [kmd_pkg::ROW_W-1:0] row,
                          input logic [kmd_pkg::MAX_LANES-1:0] levels,
                          input logic [kmd_pkg::TIME_W-1:0] now);
    int unsigned gap;
    gap = (!steady_flow && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_scan_row <= row;
    in_column_levels <= levels;
    in_now_ms <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_key_events(row, levels, now);
    rows_sent++;
  endtask

  // drop valid, wait for every predicted event, then let rows without
  // events work through the pipe before anything touches the registers
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // register write (setup + access) followed by a read-back of the same register
  task automatic write_reg(input kmd_pkg::kmd_reg_t which,
                           input logic [kmd_pkg::CFG_DW-1:0] value);
    logic [kmd_pkg::CFG_DW-1:0] readback;
    case (which)
      kmd_pkg::REG_DEBOUNCE: readback = kmd_pkg::CFG_DW'(value[kmd_pkg::DEB_W-1:0]);
      kmd_pkg::REG_SHIFT_KEY: readback = kmd_pkg::CFG_DW'(value[kmd_pkg::SHIFT_W-1:0]);
      default: readback = value;
    endcase
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 3'b000};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (which)
      kmd_pkg::REG_DEBOUNCE: cfg_debounce = value[kmd_pkg::DEB_W-1:0];
      kmd_pkg::REG_SHIFT_KEY: cfg_shift_key = value[kmd_pkg::SHIFT_W-1:0];
      default: cfg_printable = value;
    endcase
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== readback) begin
      $error("prdata mismatch at 0x%0h: expected 0x%0h, got 0x%0h", paddr, readback, prdata);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // random scan: each row follows a target pattern that drifts a few keys
  // at a time, with the odd glitch sample thrown in to restart debounce timers
  task automatic scan_random_rows(input int n_items, input int unsigned step_max,
                                  input int change_pct);
    logic [kmd_pkg::ROW_W-1:0] row;
    logic [kmd_pkg::MAX_LANES-1:0] levels;
    for (int i = 0; i < n_items; i++) begin
      row = kmd_pkg::ROW_W'($urandom_range(0, ROWS - 1));
      if ($urandom_range(0, 99) < change_pct)
        repeat ($urandom_range(1, 3))
          row_target[row][$urandom_range(0, kmd_pkg::MAX_LANES - 1)] ^= 1'b1;
      levels = ($urandom_range(0, 99) < 12) ? kmd_pkg::MAX_LANES'($urandom) : row_target[row];
      scan_clock += $urandom_range(0, step_max);
      send_row(row, levels, scan_clock);
    end
  endtask

  // reset settings: full row press, bounce, release, and a press across the time wrap
  task automatic test_debounce_and_wrap();
    send_row(3'd0, 8'hFF, 32'd0);          // raw change only
    send_row(3'd0, 8'hFF, 32'd19);         // one short of the hold time
    send_row(3'd0, 8'hFF, 32'd20);         // eight presses, key 0 is shift
    send_row(3'd0, 8'h0F, 32'd30);         // upper half starts to let go
    send_row(3'd0, 8'hFF, 32'd35);         // ...and bounces back before it counts
    send_row(3'd0, 8'h00, 32'd40);
    send_row(3'd0, 8'h00, 32'd60);         // eight releases, shift release leaves the latch
    send_row(3'd7, 8'h80, 32'hFFFF_FFFF);
    send_row(3'd7, 8'h80, 32'h0000_0013);  // held 20 ms across the rollover
    settle();
  endtask

  // zero hold time, shift key at the top index, every key printable
  task automatic test_sticky_shift();
    write_reg(kmd_pkg::REG_DEBOUNCE, 64'd0);
    write_reg(kmd_pkg::REG_SHIFT_KEY, 64'd63);
    write_reg(kmd_pkg::REG_PRINT_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    send_row(3'd7, 8'h00, 32'd100);        // release goes stable in the same sample
    send_row(3'd7, 8'h80, 32'd101);        // shift press clears the latch left from before
    send_row(3'd7, 8'h81, 32'd102);        // printable press with no shift pending
    send_row(3'd7, 8'h01, 32'd103);
    send_row(3'd7, 8'h81, 32'd104);        // shift latched
    send_row(3'd5, 8'h03, 32'd105);        // first printable press eats it, second sees none
    send_row(3'd7, 8'h00, 32'd106);
    send_row(3'd7, 8'h80, 32'd107);        // latch on
    send_row(3'd7, 8'h00, 32'd107);        // release is no toggle
    send_row(3'd7, 8'h80, 32'd108);        // second press toggles it off
    settle();
  endtask

  // longest hold time with the shift key back at index 0 and nothing printable
  task automatic test_long_debounce();
    write_reg(kmd_pkg::REG_DEBOUNCE, 64'd65535);
    write_reg(kmd_pkg::REG_SHIFT_KEY, 64'd0);
    write_reg(kmd_pkg::REG_PRINT_MASK, 64'd0);
    send_row(3'd2, 8'hAA, 32'h0000_1000);
    send_row(3'd2, 8'hAA, 32'h0000_1000 + 32'd65534);
    send_row(3'd2, 8'hAA, 32'h0000_1000 + 32'd65535);
    send_row(3'd2, 8'h55, 32'h8000_0000);
    send_row(3'd2, 8'h55, 32'h8000_FFFF);  // releases and presses interleaved by column
    settle();
  endtask

  task automatic test_random_scan();
    write_reg(kmd_pkg::REG_DEBOUNCE, 64'($urandom_range(8, 40)));
    write_reg(kmd_pkg::REG_SHIFT_KEY, 64'($urandom_range(0, 63)));
    write_reg(kmd_pkg::REG_PRINT_MASK, {$urandom, $urandom});
    scan_clock = 32'h0010_0000;
    scan_random_rows(40, 10, 40);
    settle();
  endtask

  // every change goes stable at once while the receiver sits on its hands
  task automatic test_backpressure();
    write_reg(kmd_pkg::REG_DEBOUNCE, 64'd0);
    steady_flow = 1'b1;
    hold_request = 1'b1;
    scan_random_rows(30, 2, 100);
    steady_flow = 1'b0;
    settle();
  endtask

  // longest hold time again, now with big jumps in time so keys do settle
  task automatic test_slow_random();
    write_reg(kmd_pkg::REG_DEBOUNCE, 64'd65535);
    write_reg(kmd_pkg::REG_SHIFT_KEY, 64'd63);
    write_reg(kmd_pkg::REG_PRINT_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
    scan_random_rows(30, 40000, 50);
    settle();
  endtask

  // 1 ms hold time just below the 32-bit rollover, half of it without gaps
  task automatic test_wrap_random();
    write_reg(kmd_pkg::REG_DEBOUNCE, 64'd1);
    write_reg(kmd_pkg::REG_SHIFT_KEY, 64'($urandom_range(0, 63)));
    write_reg(kmd_pkg::REG_PRINT_MASK, {$urandom, $urandom});
    scan_clock = 32'hFFFF_FF00;
    steady_flow = 1'b1;
    scan_random_rows(25, 2, 40);
    steady_flow = 1'b0;
    scan_random_rows(25, 2, 40);
    settle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_scan_row = '0;
    in_column_levels = '0;
    in_now_ms = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    steady_flow = 1'b0;
    hold_request = 1'b0;
    error_count = 0;
    cycle_count = 0;
    rows_sent = 0;
    events_checked = 0;
    presses_seen = 0;
    shifted_seen = 0;
    scan_clock = '0;
    // predictor starts from the reset state of the block
    cfg_debounce = 16'd20;
    cfg_shift_key = '0;
    cfg_printable = '0;
    shift_latched = 1'b0;
    for (int k = 0; k < NKEYS; k++) begin
      key_raw[k] = 1'b0;
      key_stable[k] = 1'b0;
      key_changed_at[k] = '0;
    end
    for (int r = 0; r < ROWS; r++) row_target[r] = '0;

    // synchronous reset, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_debounce_and_wrap();
    test_sticky_shift();
    test_long_debounce();
    test_random_scan();
    test_backpressure();
    test_slow_random();
    test_wrap_random();

    // let any stray event show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) begin
      $error("%0d predicted events never arrived", pending_events.size());
      error_count++;
    end

    $display("%0d row samples sent, %0d key events checked (%0d presses, %0d with shift set)",
             rows_sent, events_checked, presses_seen, shifted_seen);
    $display("hold times 0, 1, 20, random and 65535 ms, time rollover and a long output stall");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/kmd_pkg.sv
hdl/kmd_ram.sv
hdl/kmd_lane.sv
hdl/kmd_merge.sv
hdl/key_matrix_debounce_events_top.sv
hdl/kmd_checker.sv
tb/sv/tb_top.sv
